FILE: rtl/tor_pkg.sv
// ============================================================================
// tor_pkg - track outlier rejector shared definitions
// Field widths, the pick and job records, and the constants that both the
// window front end and the arithmetic back end use.
// ============================================================================
package tor_pkg;

    localparam int RADIUS_DEF  = 7;
    localparam int RADIUS_MAX  = 15;
    localparam int RANGE_W     = 24;
    localparam int CONF_W      = 16;
    localparam int DELTA_W     = 23;
    // distance to the earlier neighbor, and span between both neighbors
    localparam int DIST_W      = $clog2(RADIUS_MAX + 1);
    localparam int SPAN_W      = $clog2(2 * RADIUS_MAX + 1);
    // interpolation numerator: positive range times span
    localparam int NUM_W       = DELTA_W + SPAN_W;
    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [RANGE_W-1:0] REJECT_RANGE = -24'sd256;

    typedef struct packed {
        logic signed [RANGE_W-1:0] rng;
        logic [CONF_W-1:0]         conf;
        logic                      det;
        logic                      man;
    } pick_t;

    // one result to produce, already classified by the front end
    typedef struct packed {
        logic signed [RANGE_W-1:0] rng;
        logic [CONF_W-1:0]         conf;
        logic                      det;
        logic                      man;
        logic                      last;
        logic                      check;   // eligible for rejection, has a neighbor
        logic                      interp;  // both neighbors present
        logic [DELTA_W-1:0]        a;       // earlier neighbor, or the only one
        logic [DELTA_W-1:0]        b;       // later neighbor
        logic [DIST_W-1:0]         d;       // distance from earlier neighbor
        logic [SPAN_W-1:0]         span;    // distance between neighbors
    } job_t;

    typedef struct packed {
        logic valid;
        job_t job;
    } push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

FILE: rtl/tor_if.sv
// ============================================================================
// tor_if - track outlier rejector channel interfaces
// Valid/ready channels for picks in, results out and the threshold write.
// ============================================================================
interface tor_in_if import tor_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [RANGE_W-1:0] range_in;
    logic [CONF_W-1:0]         confidence_in;
    logic                      detected_in;
    logic                      manual_in;
    logic                      is_last;

    modport source (output valid, range_in, confidence_in, detected_in, manual_in,
                    is_last, input ready);
    modport sink   (input valid, range_in, confidence_in, detected_in, manual_in,
                    is_last, output ready);
endinterface

interface tor_out_if import tor_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [RANGE_W-1:0] range_out;
    logic [CONF_W-1:0]         confidence_out;
    logic                      detected_out;
    logic                      manual_out;
    logic                      last_out;

    modport source (output valid, range_out, confidence_out, detected_out, manual_out,
                    last_out, input ready);
    modport sink   (input valid, range_out, confidence_out, detected_out, manual_out,
                    last_out, output ready);
endinterface

interface tor_cfg_if import tor_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DELTA_W-1:0] max_delta;

    modport source (output valid, max_delta, input ready);
    modport sink   (input valid, max_delta, output ready);
endinterface

FILE: rtl/tor_front.sv
// ============================================================================
// tor_front - pick window and result classification
// Shifts picks through a window centered on the pick due next, finds the
// nearest positive neighbors on each side and queues one job per result.
// ============================================================================
module tor_front import tor_pkg::*; #(
    parameter int RADIUS = RADIUS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    tor_in_if.sink       picks,
    output push_t        push,
    input  q_stat_t      q_stat
);

    localparam int WIN = 2 * RADIUS + 1;
    localparam int CW  = $clog2(RADIUS + 1);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_EVAL = 2'b10
    } f_state_t;

    f_state_t           state_reg, state_next;
    logic               flush_reg, flush_next;
    logic [CW-1:0]      step_reg, step_next;
    logic [WIN-1:0]     valid_reg, valid_next;
    pick_t              win_reg [WIN];
    pick_t              win_next [WIN];

    logic               shift_en;
    logic               shift_valid;
    logic               accept;
    logic [WIN-1:0]     pos;
    pick_t              center;
    logic               have_prev, have_next;
    logic [DIST_W-1:0]  prev_dist, next_dist;
    logic [DELTA_W-1:0] prev_rng, next_rng;
    logic               flush_done;
    logic               can_go;

    assign picks.ready = (state_reg == F_IDLE);
    assign accept      = picks.valid && picks.ready;
    assign center      = win_reg[RADIUS];
    assign flush_done  = (step_reg == CW'(RADIUS));

    // positive pick flags, one per window tap
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            pos[i] = valid_reg[i] && !win_reg[i].rng[RANGE_W-1] && (win_reg[i].rng != '0);
        end
    end

    // nearest positive neighbors: farther taps first, nearer ones override
    always_comb
    begin
        have_prev = 1'b0;
        have_next = 1'b0;
        prev_dist = '0;
        next_dist = '0;
        prev_rng  = '0;
        next_rng  = '0;
        for (int k = RADIUS; k >= 1; k--)
        begin
            if (pos[RADIUS-k])
            begin
                have_prev = 1'b1;
                prev_dist = DIST_W'(k);
                prev_rng  = win_reg[RADIUS-k].rng[DELTA_W-1:0];
            end
            if (pos[RADIUS+k])
            begin
                have_next = 1'b1;
                next_dist = DIST_W'(k);
                next_rng  = win_reg[RADIUS+k].rng[DELTA_W-1:0];
            end
        end
    end

    always_comb
    begin
        push.valid      = (state_reg == F_EVAL) && valid_reg[RADIUS] && !q_stat.full;
        push.job.rng    = center.rng;
        push.job.conf   = center.conf;
        push.job.det    = center.det;
        push.job.man    = center.man;
        push.job.last   = flush_reg && flush_done;
        push.job.check  = center.det && !center.man && (have_prev || have_next);
        push.job.interp = center.det && !center.man && have_prev && have_next;
        push.job.a      = have_prev ? prev_rng : next_rng;
        push.job.b      = next_rng;
        push.job.d      = prev_dist;
        push.job.span   = SPAN_W'(prev_dist) + SPAN_W'(next_dist);
    end

    assign can_go = !valid_reg[RADIUS] || !q_stat.full;

    always_comb
    begin
        state_next  = state_reg;
        flush_next  = flush_reg;
        step_next   = step_reg;
        shift_en    = 1'b0;
        shift_valid = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    shift_en    = 1'b1;
                    shift_valid = 1'b1;
                    flush_next  = picks.is_last;
                    step_next   = '0;
                    state_next  = F_EVAL;
                end
            end
            F_EVAL:
            begin
                if (can_go)
                begin
                    if (flush_reg && !flush_done)
                    begin
                        // drain: move the next pending pick to the center
                        shift_en  = 1'b1;
                        step_next = step_reg + 1'b1;
                    end
                    else
                    begin
                        flush_next = 1'b0;
                        state_next = F_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if ((state_reg == F_EVAL) && can_go && flush_reg && flush_done)
        begin
            valid_next = '0;
        end
        else if (shift_en)
        begin
            valid_next = {shift_valid, valid_reg[WIN-1:1]};
        end
    end

    always_comb
    begin
        for (int i = 0; i < WIN - 1; i++)
        begin
            win_next[i] = shift_en ? win_reg[i+1] : win_reg[i];
        end
        win_next[WIN-1] = win_reg[WIN-1];
        if (shift_en)
        begin
            win_next[WIN-1].rng  = picks.range_in;
            win_next[WIN-1].conf = picks.confidence_in;
            win_next[WIN-1].det  = picks.detected_in;
            win_next[WIN-1].man  = picks.manual_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            flush_reg <= 1'b0;
            step_reg  <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < WIN; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

endmodule

FILE: rtl/tor_queue.sv
// ============================================================================
// tor_queue - job queue between front and back
// Small register FIFO; lets the window and the divider stall independently.
// ============================================================================
module tor_queue import tor_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output job_t    head,
    output q_stat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    job_t           mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == NW'(DEPTH));
    assign do_push    = push.valid && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.job;
        end
    end

endmodule

FILE: rtl/tor_back.sv
// ============================================================================
// tor_back - interpolation, deviation test and result register
// Forms the interpolation numerator, divides by the span one quotient bit
// per cycle, compares the deviation with the threshold and holds the result.
// ============================================================================
module tor_back import tor_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  job_t               head,
    input  q_stat_t            q_stat,
    output logic               pop,
    input  logic [DELTA_W-1:0] max_delta,
    tor_out_if.source          results
);

    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_DIV  = 4'b0100,
        B_OUT  = 4'b1000
    } b_state_t;

    b_state_t                  state_reg, state_next;
    job_t                      job_reg;
    logic [NUM_W-1:0]          quo_reg, quo_next;
    logic [SPAN_W-1:0]         rem_reg, rem_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;

    logic                      out_valid_reg, out_valid_next;
    logic signed [RANGE_W-1:0] out_rng_reg;
    logic [CONF_W-1:0]         out_conf_reg;
    logic                      out_det_reg;
    logic                      out_man_reg;
    logic                      out_last_reg;

    logic [SPAN_W:0]           trial;
    logic [SPAN_W:0]           span_ext;
    logic                      q_bit;
    logic [NUM_W-1:0]          num;
    logic [SPAN_W-1:0]         wa;
    logic [DELTA_W-1:0]        expected;
    logic [RANGE_W:0]          dev;
    logic [RANGE_W:0]          dev_abs;
    logic                      reject;
    logic                      out_load;

    assign pop = (state_reg == B_IDLE) && !q_stat.empty;

    // a*(span-d) + b*d
    assign wa  = job_reg.span - SPAN_W'(job_reg.d);
    assign num = NUM_W'(job_reg.a) * NUM_W'(wa) + NUM_W'(job_reg.b) * NUM_W'(job_reg.d);

    // restoring division step
    assign span_ext = (SPAN_W + 1)'(job_reg.span);
    assign trial    = {rem_reg, quo_reg[NUM_W-1]};
    assign q_bit    = (trial >= span_ext);

    assign expected = job_reg.interp ? quo_reg[DELTA_W-1:0] : job_reg.a;
    assign dev      = {job_reg.rng[RANGE_W-1], job_reg.rng} - {2'b00, expected};
    assign dev_abs  = dev[RANGE_W] ? (~dev + 1'b1) : dev;
    assign reject   = job_reg.check && (max_delta != '0)
                      && (dev_abs > (RANGE_W + 1)'(max_delta));

    assign out_load = (state_reg == B_OUT) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next = state_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = head.interp ? B_MUL : B_OUT;
                end
            end
            B_MUL:
            begin
                quo_next   = num;
                rem_next   = '0;
                cnt_next   = '0;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                rem_next = q_bit ? SPAN_W'(trial - span_ext) : SPAN_W'(trial);
                quo_next = {quo_reg[NUM_W-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        if (pop)
        begin
            job_reg <= head;
        end
        if (out_load)
        begin
            out_rng_reg  <= reject ? REJECT_RANGE : job_reg.rng;
            out_conf_reg <= reject ? '0 : job_reg.conf;
            out_det_reg  <= reject ? 1'b0 : job_reg.det;
            out_man_reg  <= job_reg.man;
            out_last_reg <= job_reg.last;
        end
    end

    assign results.valid          = out_valid_reg;
    assign results.range_out      = out_rng_reg;
    assign results.confidence_out = out_conf_reg;
    assign results.detected_out   = out_det_reg;
    assign results.manual_out     = out_man_reg;
    assign results.last_out       = out_last_reg;

endmodule

FILE: rtl/track_outlier_rejector.sv
// ============================================================================
// track_outlier_rejector - sliding-window seabed pick outlier rejection
// Rejects auto-detected range picks that stray from the line through their
// nearest positive neighbors; front end, job queue and divider back end.
// ============================================================================
// Each pick is released RADIUS picks after it arrives, once both sides of its
// window are known; the pick with is_last set flushes every pending pick (up
// to RADIUS+1 results, the final one marked last_out) and leaves the window
// empty for the next track. An accepted pick moves the front end from idle
// into evaluation, where the input is not ready, and a flushing pick stays in
// evaluation until every pending pick is drained; a full job queue holds the
// input off longer. A detected, non-manual result whose expected range is
// interpolated between two neighbors passes the multiply state and then the
// bit-serial divider, which produces one quotient bit of the 28-bit numerator
// per cycle; a result with one neighbor or none, or for a manual or undetected
// pick, goes from idle straight to the output state. A two-entry job queue
// decouples the window from the divider, and a result register holds a
// finished result while the back end starts on the next job. The back end
// takes one job at a time, popping the next once idle. max_delta of zero
// disables rejection; write it only while no pick is in flight. Rejected
// picks come out with range -1 m (-256), zero confidence and the detected
// flag cleared; manual picks always pass.
module track_outlier_rejector import tor_pkg::*; #(
    parameter int RADIUS = RADIUS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    tor_cfg_if.sink   cfg,
    tor_in_if.sink    picks,
    tor_out_if.source results
);

    logic [DELTA_W-1:0] max_delta_reg, max_delta_next;
    push_t              push;
    job_t               head;
    q_stat_t            q_stat;
    logic               pop;

    // threshold register: take every transfer
    assign cfg.ready      = 1'b1;
    assign max_delta_next = (cfg.valid && cfg.ready) ? cfg.max_delta : max_delta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_delta_reg <= '0;
        end
        else
        begin
            max_delta_reg <= max_delta_next;
        end
    end

    // window, neighbor search and job build
    tor_front #(
        .RADIUS (RADIUS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .picks  (picks),
        .push   (push),
        .q_stat (q_stat)
    );

    // hold classified jobs until the back end is free
    tor_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (q_stat)
    );

    // interpolate, test deviation, drive the result register
    tor_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .max_delta (max_delta_reg),
        .results   (results)
    );

    // front end never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) push.valid |-> !q_stat.full)
        else $error("job pushed into full queue");

    // back end never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !q_stat.empty)
        else $error("job popped from empty queue");

    // a pick transfer is always followed by an evaluation cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (picks.valid && picks.ready) |=> !picks.ready)
        else $error("input ready right after a pick transfer");

endmodule

FILE: bench/pick_rejection_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// pick_rejection_checker - scoreboard for the track outlier rejector
// Watches the threshold, pick and result channels. Keeps its own window of
// picks, predicts every released result and compares it with what comes out.
// ============================================================================
module pick_rejection_checker import tor_pkg::*; #(
    parameter int RADIUS = RADIUS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tor_cfg_if   cfg,
    tor_in_if    picks,
    tor_out_if   results,
    output int   fail_count,
    output int   pending
);

    localparam int WIN_DEPTH = 2 * RADIUS + 1;

    typedef struct packed {
        pick_t pick;
        logic  is_final;
    } ping_result_t;

    pick_t              ping_window [WIN_DEPTH];
    int                 window_fill;
    int                 release_pos;
    logic [DELTA_W-1:0] delta_limit;
    ping_result_t       expected_pings [$];
    int                 mismatches = 0;
    ping_result_t       want;
    ping_result_t       got;

    // Work out the result for the pick at window position pos.
    function automatic ping_result_t release_ping(int pos, bit is_final);
        ping_result_t res;
        int           earlier;
        int           later;
        int           lo;
        int           hi;
        int           j;
        longint       a;
        longint       b;
        longint       span;
        longint       offs;
        longint       ideal;
        longint       dev;
        bit           have;
        res.pick     = ping_window[pos];
        res.is_final = is_final;
        if (delta_limit != '0 && res.pick.det && !res.pick.man)
        begin
            earlier = -1;
            later   = -1;
            lo      = (pos - RADIUS < 0) ? 0 : pos - RADIUS;
            hi      = (pos + RADIUS > window_fill - 1) ? window_fill - 1 : pos + RADIUS;
            for (j = pos - 1; j >= lo; j--)
                if (earlier < 0 && $signed(ping_window[j].rng) > 0)
                    earlier = j;
            for (j = pos + 1; j <= hi; j++)
                if (later < 0 && $signed(ping_window[j].rng) > 0)
                    later = j;
            have  = 1'b1;
            ideal = 0;
            a     = (earlier >= 0) ? longint'($signed(ping_window[earlier].rng)) : 0;
            b     = (later >= 0) ? longint'($signed(ping_window[later].rng)) : 0;
            if (earlier >= 0 && later >= 0)
            begin
                span  = longint'(later - earlier);
                offs  = longint'(pos - earlier);
                ideal = (a * (span - offs) + b * offs) / span;
            end
            else if (earlier >= 0)
                ideal = a;
            else if (later >= 0)
                ideal = b;
            else
                have = 1'b0;
            if (have)
            begin
                dev = longint'($signed(res.pick.rng)) - ideal;
                if (dev < 0)
                    dev = -dev;
                if (dev > longint'(delta_limit))
                begin
                    res.pick.rng  = REJECT_RANGE;
                    res.pick.conf = '0;
                    res.pick.det  = 1'b0;
                end
            end
        end
        return res;
    endfunction

    task automatic clear_window();
        for (int i = 0; i < WIN_DEPTH; i++)
            ping_window[i] = '0;
        window_fill = 0;
        release_pos = 0;
    endtask

    // Append one predicted result behind those already waiting.
    function automatic void queue_ping(ping_result_t r);
        expected_pings = {expected_pings, r};
    endfunction

    // Take one accepted pick into the window and queue what it releases.
    task automatic absorb_ping(pick_t p, bit is_final);
        if (window_fill >= WIN_DEPTH)
        begin
            for (int i = 0; i < WIN_DEPTH - 1; i++)
                ping_window[i] = ping_window[i + 1];
            window_fill = WIN_DEPTH - 1;
            if (release_pos > 0)
                release_pos--;
        end
        ping_window[window_fill] = p;
        window_fill++;
        if (is_final)
        begin
            while (release_pos < window_fill)
            begin
                queue_ping(release_ping(release_pos, release_pos == window_fill - 1));
                release_pos++;
            end
            clear_window();
        end
        else if (window_fill - release_pos > RADIUS)
        begin
            queue_ping(release_ping(release_pos, 1'b0));
            release_pos++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_window();
            delta_limit = '0;
            expected_pings.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                delta_limit = cfg.max_delta;
            if (picks.valid && picks.ready)
                absorb_ping('{rng: picks.range_in, conf: picks.confidence_in,
                              det: picks.detected_in, man: picks.manual_in},
                            picks.is_last);
            if (results.valid && results.ready)
            begin
                got.pick.rng  = results.range_out;
                got.pick.conf = results.confidence_out;
                got.pick.det  = results.detected_out;
                got.pick.man  = results.manual_out;
                got.is_final  = results.last_out;
                if (expected_pings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result transfer with none outstanding: rng %0d",
                                 $time, $signed(got.pick.rng));
                end
                else
                begin
                    want = expected_pings.pop_front();
                    if (got.pick.rng !== want.pick.rng || got.pick.conf !== want.pick.conf ||
                        got.pick.det !== want.pick.det || got.pick.man !== want.pick.man ||
                        got.is_final !== want.is_final)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result differs: expected rng %0d conf %h det %b ",
                                      "man %b last %b, got rng %0d conf %h det %b man %b ",
                                      "last %b"}, $time,
                                     $signed(want.pick.rng), want.pick.conf, want.pick.det,
                                     want.pick.man, want.is_final,
                                     $signed(got.pick.rng), got.pick.conf, got.pick.det,
                                     got.pick.man, got.is_final);
                    end
                end
            end
            pending    <= expected_pings.size();
            fail_count <= mismatches;
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench - track outlier rejector top-level bench
// Drives tracks of range picks and threshold writes into the block with
// random gaps and result backpressure; the checker beside it predicts and
// compares every result, and this module reports the verdict.
// ============================================================================
module testbench;
    import tor_pkg::*;

    localparam int RADIUS        = RADIUS_DEF;
    localparam int RANDOM_PINGS  = 350;
    // wait this long after the last outstanding result has come out before
    // touching the threshold
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_CYCLES  = 100;
    localparam int LIMIT_NS      = 2_000_000;

    localparam logic [DELTA_W-1:0]        DELTA_MAX = '1;
    localparam logic signed [RANGE_W-1:0] RANGE_MAX = 24'sh7FFFFF;
    localparam logic signed [RANGE_W-1:0] RANGE_MIN = 24'sh800000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;

    // sender and receiver idling state
    bit   no_gaps      = 1'b0;
    bit   steady_ready = 1'b0;
    int   stall_left   = 0;
    int   mode_left    = 0;
    int   ready_roll;
    logic ready_next;
    int   random_pings = 0;

    tor_cfg_if cfg_ch ();
    tor_in_if  pick_ch ();
    tor_out_if result_ch ();

    track_outlier_rejector #(.RADIUS(RADIUS)) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .picks   (pick_ch),
        .results (result_ch)
    );

    pick_rejection_checker #(.RADIUS(RADIUS)) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_ch),
        .picks      (pick_ch),
        .results    (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Result backpressure: alternate between stretches of steady ready and
    // stretches with short and occasional long stalls.
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            steady_ready = ($urandom_range(0, 3) == 0);
            mode_left    = int'($urandom_range(50, 300));
        end
        else
            mode_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            ready_next = 1'b0;
        end
        else if (steady_ready)
            ready_next = 1'b1;
        else
        begin
            ready_roll = int'($urandom_range(0, 99));
            if (ready_roll < 65)
                ready_next = 1'b1;
            else
            begin
                ready_next = 1'b0;
                stall_left = (ready_roll < 95) ? int'($urandom_range(0, 2))
                                               : int'($urandom_range(10, 60));
            end
        end
        result_ch.ready <= ready_next;
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int draw_gap();
        int roll;
        roll = int'($urandom_range(0, 99));
        if (no_gaps || roll < 55)
            return 0;
        if (roll < 90)
            return int'($urandom_range(1, 3));
        return int'($urandom_range(10, 60));
    endfunction

    // Present one pick and hold it until the transfer. Valid stays high when
    // the next pick follows with no gap.
    task automatic send_ping(input logic signed [RANGE_W-1:0] rng,
                             input logic [CONF_W-1:0] conf,
                             input logic det, input logic man, input logic is_final);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            pick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pick_ch.valid         <= 1'b1;
        pick_ch.range_in      <= rng;
        pick_ch.confidence_in <= conf;
        pick_ch.detected_in   <= det;
        pick_ch.manual_in     <= man;
        pick_ch.is_last       <= is_final;
        do
            @(posedge clk);
        while (!pick_ch.ready);
    endtask

    // Drop valid and hold until every outstanding result has come out.
    task automatic wait_drained();
        pick_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write the threshold only with the block idle between tracks.
    task automatic set_max_delta(input logic [DELTA_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.max_delta <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random track: a sloped seabed with noise, sprinkled with outliers,
    // missing picks, arbitrary words and the range extremes.
    task automatic random_track(input int len);
        int                        base;
        int                        slope;
        int                        roll;
        int                        val;
        logic signed [RANGE_W-1:0] rng;
        base  = int'($urandom_range(1, 4_000_000));
        slope = int'($urandom_range(0, 400)) - 200;
        for (int i = 0; i < len; i++)
        begin
            // pause mid-track now and then until the pipeline empties
            if ($urandom_range(0, 49) == 0)
                wait_drained();
            roll = int'($urandom_range(0, 99));
            val  = base + slope * i + int'($urandom_range(0, 128)) - 64;
            if (roll < 70)
                rng = RANGE_W'(val);
            else if (roll < 80)
                rng = ($urandom_range(0, 1) != 0)
                      ? RANGE_W'(val + int'($urandom_range(256, 100_000)))
                      : RANGE_W'(val - int'($urandom_range(256, 100_000)));
            else if (roll < 88)
                rng = RANGE_W'(-int'($urandom_range(0, 1000)));
            else if (roll < 95)
                rng = RANGE_W'($urandom);
            else
                rng = ($urandom_range(0, 1) != 0) ? RANGE_MAX : RANGE_MIN;
            send_ping(rng, CONF_W'($urandom_range(0, 65535)), $urandom_range(0, 9) != 0,
                      $urandom_range(0, 9) == 0, i == len - 1);
            random_pings++;
        end
    endtask

    initial
    begin : stimulus
        int                        roll;
        int                        len;
        logic signed [RANGE_W-1:0] rng;
        logic                      det;
        logic                      man;
        logic [DELTA_W-1:0]        limit;

        cfg_ch.valid          = 1'b0;
        cfg_ch.max_delta      = '0;
        pick_ch.valid         = 1'b0;
        pick_ch.range_in      = '0;
        pick_ch.confidence_in = '0;
        pick_ch.detected_in   = 1'b0;
        pick_ch.manual_in     = 1'b0;
        pick_ch.is_last       = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Threshold still at its reset value of zero: everything passes,
        // including the range extremes and a detected pick with no range.
        send_ping(RANGE_MAX, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        send_ping(RANGE_MIN, 16'h0000, 1'b1, 1'b0, 1'b0);
        send_ping('0, 16'h1234, 1'b1, 1'b0, 1'b0);
        send_ping(24'sd1, 16'h5A5A, 1'b1, 1'b1, 1'b1);

        // A sloped track long enough to slide the window, with a detected
        // outlier, a manual outlier, a detected pick with no range, an
        // undetected outlier and both range extremes among detected picks.
        set_max_delta(23'd512);
        for (int i = 0; i < 16; i++)
        begin
            rng = RANGE_W'(10_000 + 100 * i);
            det = 1'b1;
            man = 1'b0;
            case (i)
                3:  rng = RANGE_W'(rng + 5000);
                5:
                begin
                    rng = RANGE_W'(rng + 5000);
                    man = 1'b1;
                end
                7:  rng = '0;
                9:
                begin
                    rng = RANGE_W'(rng + 5000);
                    det = 1'b0;
                end
                11: rng = RANGE_MIN;
                12: rng = RANGE_MAX;
                default: ;
            endcase
            send_ping(rng, CONF_W'(16'h1000 + i), det, man, i == 15);
        end

        // Widest threshold: a single-pick track, a track with no positive
        // neighbor at all, and both extremes, the minimum still exceeding the threshold.
        set_max_delta(DELTA_MAX);
        send_ping(24'sd5000, 16'h8000, 1'b1, 1'b0, 1'b1);
        send_ping(-24'sd5, 16'h0001, 1'b1, 1'b0, 1'b0);
        send_ping('0, 16'h0002, 1'b1, 1'b0, 1'b1);
        send_ping(RANGE_MAX, 16'h7FFF, 1'b1, 1'b0, 1'b0);
        send_ping(RANGE_MIN, 16'hFFFE, 1'b1, 1'b0, 1'b1);

        // Random tracks, each under its own threshold.
        while (random_pings < RANDOM_PINGS)
        begin
            roll = int'($urandom_range(0, 99));
            if (roll < 10)
                limit = '0;
            else if (roll < 15)
                limit = 23'd1;
            else if (roll < 22)
                limit = DELTA_MAX;
            else if (roll < 80)
                limit = DELTA_W'($urandom_range(1, 4096));
            else
                limit = DELTA_W'($urandom);
            set_max_delta(limit);
            no_gaps = ($urandom_range(0, 3) == 0);
            roll    = int'($urandom_range(0, 99));
            if (roll < 10)
                len = 1;
            else if (roll < 85)
                len = int'($urandom_range(2, 25));
            else
                len = int'($urandom_range(26, 60));
            random_track(len);
        end

        // Every track ended with a final pick, so nothing may stay behind.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Stop a hung run.
    initial
    begin
        #LIMIT_NS;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tor_pkg.sv
rtl/tor_if.sv
rtl/tor_front.sv
rtl/tor_queue.sv
rtl/tor_back.sv
rtl/track_outlier_rejector.sv
bench/pick_rejection_checker.sv
bench/testbench.sv
